// ===== sv/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared definitions for the rational arithmetic unit
// Word widths, command and status codes, and divider handshake types.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(PROD_BITS);
    localparam int SHF_BITS  = $clog2(PROD_BITS);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_RED = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== sv/rau_if.sv =====
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if: valid/ready channels of the rational unit
// Operand item channel and result item channel.
// ----------------------------------------------------------------------------
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic signed [rau_pkg::WORD_BITS-1:0] a_num;
    logic signed [rau_pkg::WORD_BITS-1:0] a_den;
    logic signed [rau_pkg::WORD_BITS-1:0] b_num;
    logic signed [rau_pkg::WORD_BITS-1:0] b_den;

    modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [rau_pkg::WORD_BITS-1:0] res_num;
    logic [rau_pkg::WORD_BITS-2:0]        res_den;
    logic [1:0]  status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== sv/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div: iterative restoring divider
// One quotient bit per cycle over a double-width dividend.
// ----------------------------------------------------------------------------
module rau_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rau_pkg::PROD_BITS-1:0] i_dividend,
    input  logic [rau_pkg::PROD_BITS-1:0] i_divisor,
    output rau_pkg::t_div_status          o_stat,
    output logic [rau_pkg::PROD_BITS-1:0] o_quot
);
    logic                          r_busy;
    logic                          r_done;
    logic [rau_pkg::CNT_BITS-1:0]  r_cnt;
    logic [rau_pkg::PROD_BITS-1:0] r_rem;
    logic [rau_pkg::PROD_BITS-1:0] r_quo;
    logic [rau_pkg::PROD_BITS-1:0] r_d;
    logic [rau_pkg::PROD_BITS:0]   shifted;
    logic [rau_pkg::PROD_BITS:0]   diff;

    // trial subtract of the divisor from the shifted remainder
    assign shifted = {r_rem, r_quo[rau_pkg::PROD_BITS-1]};
    assign diff    = shifted - {1'b0, r_d};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rau_pkg::CNT_BITS'(rau_pkg::PROD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: keep the remainder, shift in quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= diff[rau_pkg::PROD_BITS] ? shifted[rau_pkg::PROD_BITS-1:0]
                                              : diff[rau_pkg::PROD_BITS-1:0];
            r_quo <= {r_quo[rau_pkg::PROD_BITS-2:0], ~diff[rau_pkg::PROD_BITS]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact fraction arithmetic with GCD reduction
// Sequence: zero-denominator items go straight to the output stage; a zero
//   numerator ends after products, fold and zero check; otherwise products,
//   fold, zero check, binary GCD, two restoring divides, range check, output.
// Throughput: one item at a time; the shared GCD loop and divider set the rate, and a stalled output holds it.
// Reset: synchronous active low, clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rau_in_if.sink       i_in,
    rau_out_if.source    o_out
);
    localparam int W = rau_pkg::WORD_BITS;
    localparam int P = rau_pkg::PROD_BITS;
    localparam logic [P-1:0] HALF = P'(1) << (W - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_COMB, S_ZCHK, S_GCD,
        S_DIVN_GO, S_DIVN, S_DIVD_GO, S_DIVD, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0]   r_cmd;
    logic         r_an_s, r_ad_s, r_bn_s, r_bd_s;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic         r_nneg, r_tneg, r_dneg;
    logic [P-1:0] r_num, r_t, r_den;
    logic [P-1:0] r_u, r_v, r_g, r_qn;
    logic [rau_pkg::SHF_BITS-1:0] r_k;
    logic signed [W-1:0] r_pnum;
    logic [W-2:0] r_pden;
    logic [1:0]   r_pstat;
    logic         r_out_valid;
    logic signed [W-1:0] r_res_num;
    logic [W-2:0] r_res_den;
    logic [1:0]   r_status;

    logic [W-1:0] an_m, ad_m, bn_m, bd_m, mul_x, mul_y;
    logic [P-1:0] prod, u_minus_v, v_minus_u, nm, dm, nlim;
    logic         zero_den, is_red, neg, div_start;
    logic [P-1:0] div_dividend, quot;
    rau_pkg::t_div_status div_stat;

    // magnitudes of the incoming operands
    assign an_m = i_in.a_num[W-1] ? -i_in.a_num : i_in.a_num;
    assign ad_m = i_in.a_den[W-1] ? -i_in.a_den : i_in.a_den;
    assign bn_m = i_in.b_num[W-1] ? -i_in.b_num : i_in.b_num;
    assign bd_m = i_in.b_den[W-1] ? -i_in.b_den : i_in.b_den;

    always_comb begin
        zero_den = (i_in.a_den == '0);
        if (i_in.command <= rau_pkg::CMD_DIV && i_in.b_den == '0) zero_den = 1'b1;
        if (i_in.command == rau_pkg::CMD_DIV && i_in.b_num == '0) zero_den = 1'b1;
    end

    assign is_red = (r_cmd > rau_pkg::CMD_DIV);

    // shared multiplier operand selection
    always_comb begin
        mul_x = r_an;
        mul_y = r_bd;
        case (r_state)
            S_MUL0: begin
                mul_x = r_an;
                mul_y = is_red ? W'(1) : ((r_cmd == rau_pkg::CMD_MUL) ? r_bn : r_bd);
            end
            S_MUL1: begin
                mul_x = r_bn;
                mul_y = r_ad;
            end
            default: begin
                mul_x = r_ad;
                mul_y = is_red ? W'(1) : ((r_cmd == rau_pkg::CMD_DIV) ? r_bn : r_bd);
            end
        endcase
    end
    assign prod = mul_x * mul_y;

    assign u_minus_v = r_u - r_v;
    assign v_minus_u = r_v - r_u;

    // result check
    assign nm   = r_qn;
    assign dm   = quot;
    assign neg  = r_nneg ^ r_dneg;
    assign nlim = neg ? HALF : HALF - P'(1);

    assign div_start    = (r_state == S_DIVN_GO) || (r_state == S_DIVD_GO);
    assign div_dividend = (r_state == S_DIVN_GO) ? r_num : r_den;

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_g),
        .o_stat     (div_stat),
        .o_quot     (quot)
    );

    // sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one is loaded below
            if (o_out.ready && r_state != S_OUT) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd  <= i_in.command;
                        r_an   <= an_m;  r_an_s <= i_in.a_num[W-1];
                        r_ad   <= ad_m;  r_ad_s <= i_in.a_den[W-1];
                        r_bn   <= bn_m;  r_bn_s <= i_in.b_num[W-1];
                        r_bd   <= bd_m;  r_bd_s <= i_in.b_den[W-1];
                        if (zero_den) begin
                            r_pnum  <= '0;
                            r_pden  <= '0;
                            r_pstat <= rau_pkg::ST_ZERO_DEN;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MUL0;
                        end
                    end
                end
                S_MUL0: begin
                    r_num <= prod;
                    if (is_red) r_nneg <= r_an_s;
                    else if (r_cmd == rau_pkg::CMD_MUL) r_nneg <= r_an_s ^ r_bn_s;
                    else r_nneg <= r_an_s ^ r_bd_s;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_t     <= prod;
                    r_tneg  <= r_bn_s ^ r_ad_s ^ (r_cmd == rau_pkg::CMD_SUB);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_den <= prod;
                    if (is_red) r_dneg <= r_ad_s;
                    else if (r_cmd == rau_pkg::CMD_DIV) r_dneg <= r_ad_s ^ r_bn_s;
                    else r_dneg <= r_ad_s ^ r_bd_s;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    // fold the second cross product in for add and subtract
                    if (r_cmd == rau_pkg::CMD_ADD || r_cmd == rau_pkg::CMD_SUB) begin
                        if (r_nneg == r_tneg) begin
                            r_num <= r_num + r_t;
                        end else if (r_num >= r_t) begin
                            r_num <= r_num - r_t;
                        end else begin
                            r_num  <= r_t - r_num;
                            r_nneg <= r_tneg;
                        end
                    end
                    r_state <= S_ZCHK;
                end
                S_ZCHK: begin
                    if (r_num == '0) begin
                        r_pnum  <= '0;
                        r_pden  <= (W-1)'(1);
                        r_pstat <= rau_pkg::ST_OK;
                        r_state <= S_OUT;
                    end else begin
                        r_u     <= r_num;
                        r_v     <= r_den;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    // one binary GCD step
                    if (r_u == '0) begin
                        r_g     <= r_v << r_k;
                        r_state <= S_DIVN_GO;
                    end else if (r_v == '0) begin
                        r_g     <= r_u << r_k;
                        r_state <= S_DIVN_GO;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u >= r_v) begin
                        r_u <= u_minus_v;
                    end else begin
                        r_v <= v_minus_u;
                    end
                end
                S_DIVN_GO: r_state <= S_DIVN;
                S_DIVN: begin
                    if (div_stat.done) begin
                        r_qn    <= quot;
                        r_state <= S_DIVD_GO;
                    end
                end
                S_DIVD_GO: r_state <= S_DIVD;
                S_DIVD: begin
                    if (div_stat.done) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (nm > nlim || dm > HALF - P'(1)) begin
                        r_pnum  <= '0;
                        r_pden  <= '0;
                        r_pstat <= rau_pkg::ST_RANGE;
                    end else begin
                        r_pnum  <= neg ? -nm[W-1:0] : nm[W-1:0];
                        r_pden  <= dm[W-2:0];
                        r_pstat <= rau_pkg::ST_OK;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hand over once the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_res_num   <= r_pnum;
                        r_res_den   <= r_pden;
                        r_status    <= r_pstat;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.res_num = r_res_num;
    assign o_out.res_den = r_res_den;
    assign o_out.status  = r_status;

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_u != '0 || r_v != '0))
        else $error("GCD operands both zero");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVN || r_state == S_DIVD) && !div_stat.done |-> div_stat.busy)
        else $error("waiting on an idle divider");
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == rau_pkg::ST_OK |-> r_res_den != '0)
        else $error("ok result with zero denominator");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> $stable(r_res_num) && $stable(r_status))
        else $error("pending result overwritten");
endmodule

// ===== dv/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the rational unit
// Feeds directed and random fraction items through the operand channel,
// predicts each reduced fraction and status, and compares the results in
// order while both channels idle and stall in several phases.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } t_operands;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic [1:0]  status;
    } t_fraction;

    logic i_clk;
    logic i_rst_n;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_operands pending_ops[$];
    t_fraction expected_fracs[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off_left;
    bit        hold_off_req;
    int        mismatch_count;
    int        result_count;
    int        quiet_cycles;
    bit        timed_out;
    int        cmd_seen[8];
    int        status_seen[4];

    // Clock and reset
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Magnitude of a word, widened to 64 bits
    function automatic logic [63:0] word_mag(input logic [31:0] w);
        return {32'd0, w[31] ? 32'(-w) : w};
    endfunction

    // Predict the reduced fraction for one operand item
    function automatic t_fraction reduce_fraction(input t_operands op);
        logic [63:0] anm, adm, bnm, bdm, pm, qm, nm, dm, g, p, q, t;
        logic        an_s, ad_s, bn_s, bd_s, ps, qs, neg;
        logic [63:0] x_mag, y_mag;
        logic        x_s, y_s;
        t_fraction   r;
        r = '0;
        anm = word_mag(op.a_num); an_s = op.a_num[31];
        adm = word_mag(op.a_den); ad_s = op.a_den[31];
        bnm = word_mag(op.b_num); bn_s = op.b_num[31];
        bdm = word_mag(op.b_den); bd_s = op.b_den[31];
        if (adm == 0 || (op.command <= rau_pkg::CMD_DIV && bdm == 0) ||
                (op.command == rau_pkg::CMD_DIV && bnm == 0)) begin
            r.status = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        case (op.command) inside
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                if (op.command == rau_pkg::CMD_SUB) bn_s = ~bn_s;
                x_mag = anm * bdm; x_s = an_s ^ bd_s;
                y_mag = bnm * adm; y_s = bn_s ^ ad_s;
                if (x_s == y_s) begin
                    pm = x_mag + y_mag; ps = x_s;
                end else if (x_mag >= y_mag) begin
                    pm = x_mag - y_mag; ps = x_s;
                end else begin
                    pm = y_mag - x_mag; ps = y_s;
                end
                qm = adm * bdm; qs = ad_s ^ bd_s;
            end
            rau_pkg::CMD_MUL: begin
                pm = anm * bnm; ps = an_s ^ bn_s;
                qm = adm * bdm; qs = ad_s ^ bd_s;
            end
            rau_pkg::CMD_DIV: begin
                pm = anm * bdm; ps = an_s ^ bd_s;
                qm = adm * bnm; qs = ad_s ^ bn_s;
            end
            default: begin
                pm = anm; ps = an_s;
                qm = adm; qs = ad_s;
            end
        endcase
        if (pm == 0) begin
            r.res_den = 31'd1;
            return r;
        end
        p = pm; q = qm;
        while (q != 0) begin
            t = p % q; p = q; q = t;
        end
        g = p;
        nm = pm / g; dm = qm / g;
        neg = ps ^ qs;
        if (nm > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF) || dm > 64'h7FFF_FFFF) begin
            r.status = rau_pkg::ST_RANGE;
            return r;
        end
        r.res_num = neg ? 32'(-nm) : nm[31:0];
        r.res_den = dm[30:0];
        r.status  = rau_pkg::ST_OK;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 12) - 6;
            1:       return 32'h8000_0000 + $urandom_range(0, 2);
            2:       return 32'h7FFF_FFFF - $urandom_range(0, 2);
            3:       return $urandom_range(0, 2000) - 1000;
            4:       return $urandom & 32'h0000_FFFF ^ {32{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_operands rand_item();
        t_operands op;
        op.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
        op.a_num = rand_word();
        op.a_den = rand_word();
        op.b_num = rand_word();
        op.b_den = rand_word();
        // keep most denominators nonzero so reduction is exercised
        if (op.a_den == 0 && $urandom_range(0, 3) != 0) op.a_den = 32'd7;
        if (op.b_den == 0 && $urandom_range(0, 3) != 0) op.b_den = 32'hFFFF_FFFD;
        return op;
    endfunction

    function automatic t_operands make_item(input logic [2:0] c, input logic [31:0] an,
                                            input logic [31:0] ad, input logic [31:0] bn,
                                            input logic [31:0] bd);
        t_operands op;
        op.command = c; op.a_num = an; op.a_den = ad; op.b_num = bn; op.b_den = bd;
        return op;
    endfunction

    // Operand driver: offer the queue head, advance on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the offered item
        end else begin
            if (in_ch.valid && in_ch.ready) void'(pending_ops.pop_front());
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_ch.valid   <= 1'b1;
                in_ch.command <= pending_ops[0].command;
                in_ch.a_num   <= pending_ops[0].a_num;
                in_ch.a_den   <= pending_ops[0].a_den;
                in_ch.b_num   <= pending_ops[0].b_num;
                in_ch.b_den   <= pending_ops[0].b_den;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            expected_fracs.push_back(reduce_fraction(make_item(in_ch.command, in_ch.a_num,
                                     in_ch.a_den, in_ch.b_num, in_ch.b_den)));
            cmd_seen[in_ch.command]++;
        end
    end

    // Result sink ready: random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready  <= 1'b0;
            hold_off_left <= 0;
        end else if (hold_off_req && hold_off_left == 0) begin
            hold_off_left <= 3000;
            out_ch.ready  <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            out_ch.ready  <= (hold_off_left == 1);
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result monitor: compare with the oldest expectation
    always @(posedge i_clk) begin
        t_fraction got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.res_num = out_ch.res_num;
            got.res_den = out_ch.res_den;
            got.status  = out_ch.status;
            result_count++;
            if (expected_fracs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result num=%0d den=%0d st=%0d",
                             $signed(got.res_num), got.res_den, got.status);
            end else begin
                want = expected_fracs.pop_front();
                status_seen[want.status]++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result %0d exp %0d/%0d st %0d, got %0d/%0d st %0d",
                                 result_count, $signed(want.res_num), want.res_den,
                                 want.status, $signed(got.res_num), got.res_den,
                                 got.status);
                end
            end
        end
    end

    // Watchdog: cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !timed_out) begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_ch.valid || expected_fracs.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) pending_ops.push_back(rand_item());
        wait_drained();
    endtask

    // Stimulus
    initial begin
        send_idle_pct = 0; recv_stall_pct = 0; hold_off_req = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command, zero denominators, zero result, range
        pending_ops.push_back(make_item(rau_pkg::CMD_ADD, 1, 2, 1, 3));
        pending_ops.push_back(make_item(rau_pkg::CMD_SUB, 1, 2, 1, 2));
        pending_ops.push_back(make_item(rau_pkg::CMD_MUL, -6, 4, 2, -9));
        pending_ops.push_back(make_item(rau_pkg::CMD_DIV, 3, 4, -3, 8));
        pending_ops.push_back(make_item(rau_pkg::CMD_RED, -10, -4, 0, 0));
        pending_ops.push_back(make_item(3'd5, 12, 18, 5, 0));
        pending_ops.push_back(make_item(3'd6, 32'h8000_0000, 1, 0, 0));
        pending_ops.push_back(make_item(3'd7, 32'h8000_0000, -1, 0, 0));
        pending_ops.push_back(make_item(rau_pkg::CMD_RED, 5, 32'h8000_0000, 0, 0));
        pending_ops.push_back(make_item(rau_pkg::CMD_ADD, 1, 0, 1, 1));
        pending_ops.push_back(make_item(rau_pkg::CMD_ADD, 1, 1, 1, 0));
        pending_ops.push_back(make_item(rau_pkg::CMD_DIV, 1, 1, 0, 1));
        pending_ops.push_back(make_item(rau_pkg::CMD_RED, 0, 0, 3, 3));
        pending_ops.push_back(make_item(rau_pkg::CMD_MUL, 0, 32'h8000_0000, 5, 7));
        pending_ops.push_back(make_item(rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 1,
                                        32'h7FFF_FFFF, 1));
        pending_ops.push_back(make_item(rau_pkg::CMD_MUL, 32'h8000_0000, 1,
                                        32'h8000_0000, 1));
        pending_ops.push_back(make_item(rau_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
        pending_ops.push_back(make_item(rau_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                                        32'h8000_0000, 32'h7FFF_FFFF));
        pending_ops.push_back(make_item(rau_pkg::CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h7FFF_FFFF));
        pending_ops.push_back(make_item(rau_pkg::CMD_DIV, -1, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF, -1));
        pending_ops.push_back(make_item(rau_pkg::CMD_RED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        0, 0));
        pending_ops.push_back(make_item(rau_pkg::CMD_RED, 32'h5555_5555, 32'hAAAA_AAAA,
                                        -1, -1));
        wait_drained();

        // Random phases with varied idling
        run_phase(0, 0, 400);
        run_phase(70, 0, 350);
        run_phase(0, 70, 350);
        run_phase(14, 14, 300);
        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0; recv_stall_pct = 0;
        repeat (20) pending_ops.push_back(rand_item());
        hold_off_req = 1'b1;
        wait (hold_off_left != 0);
        hold_off_req = 1'b0;
        wait_drained();
        run_phase(30, 30, 300);
        run_phase(0, 0, 280);

        repeat (400) @(posedge i_clk);
        $display("Run covered %0d results; commands 0-7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 result_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3],
                 cmd_seen[4], cmd_seen[5], cmd_seen[6], cmd_seen[7]);
        $display("Statuses ok/zero-den/range: %0d %0d %0d, mismatches %0d",
                 status_seen[0], status_seen[1], status_seen[2], mismatch_count);
        if (mismatch_count == 0 && expected_fracs.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rau_pkg.sv
sv/rau_if.sv
sv/rau_div.sv
sv/rational_arithmetic_unit.sv
dv/rational_arithmetic_unit_tb.sv
